[src/tccw_pkg.sv]
package tccw_pkg;

  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned MAG_W      = 64;
  localparam int unsigned DIG_IDX_W  = 5;

  localparam logic       REQ_CHAR     = 1'b0;
  localparam logic       REQ_NUMBER   = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;
  localparam logic [7:0] MINUS_SIGN   = 8'h2D;
  localparam logic [7:0] COLOR_RESET  = 8'd15;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         char_code;
    logic signed [63:0] number;
  } req_t;

  typedef struct packed {
    logic [10:0] cell_address;
    logic [15:0] cell_value;
    logic        last_of_run;
  } cell_t;

  typedef struct packed {
    logic advance;
    logic newline;
  } cursor_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

[src/tccw_dabble.sv]
module tccw_dabble (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tccw_pkg::MAG_W-1:0] mag_i,
  output logic                       busy_o,
  output logic [tccw_pkg::BCD_W-1:0] bcd_o
);
  import tccw_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAG_W / 2);

  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [MAG_W-1:0] bin_q, bin_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;

  function automatic logic [BCD_W+MAG_W-1:0] dabble_step(logic [BCD_W+MAG_W-1:0] v);
    logic [BCD_W+MAG_W-1:0] r;
    r = v;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (r[MAG_W+4*i +: 4] >= 4'd5) begin
        r[MAG_W+4*i +: 4] = r[MAG_W+4*i +: 4] + 4'd3;
      end
    end
    return {r[BCD_W+MAG_W-2:0], 1'b0};
  endfunction

  always_comb begin
    logic [BCD_W+MAG_W-1:0] v;
    bcd_d  = bcd_q;
    bin_d  = bin_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    v      = dabble_step(dabble_step({bcd_q, bin_q}));
    if (start_i) begin
      bcd_d  = '0;
      bin_d  = mag_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = v[BCD_W+MAG_W-1:MAG_W];
      bin_d = v[MAG_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(MAG_W / 2 - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign busy_o = busy_q;
  assign bcd_o  = bcd_q;

endmodule

[src/tccw_cursor.sv]
module tccw_cursor #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tccw_pkg::cursor_cmd_t cmd_i,
  output logic [10:0]           addr_o
);
  import tccw_pkg::*;

  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned AW = $clog2(COLUMNS * ROWS);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] addr;
  logic [AW+10:0] addr_ext;
  logic          next_row;

  assign addr     = base_q + AW'(col_q);
  assign addr_ext = {11'b0, addr};
  assign addr_o   = addr_ext[10:0];

  assign next_row = cmd_i.newline || (cmd_i.advance && col_q == CW'(COLUMNS - 1));

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (next_row) begin
      col_d = '0;
      if (row_q == RW'(ROWS - 1)) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d  = row_q + 1'b1;
        base_d = base_q + AW'(COLUMNS);
      end
    end else if (cmd_i.advance) begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      base_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < COLUMNS)
    else $error("cursor column out of range");

  a_row_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q == AW'(row_q * COLUMNS))
    else $error("row base out of step with row");

  a_newline_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.newline |=> col_q == '0)
    else $error("newline did not return to column zero");

endmodule

[src/text_console_cell_writer_top.sv]
// Text console cell writer: each request beat is a character or a signed 64-bit number and
// turns into 16-bit cell writes {text_color, code} at a cursor on a ROWS x COLUMNS grid,
// with last_of_run set on the final write of a request. A character yields one output beat;
// a newline is absorbed in the accept cycle and writes nothing. A number runs through the
// double-dabble unit, two bits per cycle: after accept it waits in conversion until the unit
// finishes, passes a digit scan state, then writes one cell at a time (sign plus up to 19
// digits), each cell waiting for a free output slot. Input is stalled from accept until the
// last cell of the request has been loaded into the output register; a waiting output beat
// does not block a new request. text_color may be written at any time and applies to cells
// loaded after it.
module text_console_cell_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tccw_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tccw_pkg::cell_t out_cell_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [7:0]      cfg_data_i
);
  import tccw_pkg::*;

  state_e                 state_q, state_d;
  logic [7:0]             color_q;
  logic                   is_char_q, is_char_d;
  logic [7:0]             char_q, char_d;
  logic                   neg_q, neg_d;
  logic [DIG_IDX_W-1:0]   dig_idx_q, dig_idx_d;
  logic                   out_valid_q;
  cell_t                  out_cell_q, out_cell_d;
  logic                   out_load;

  logic                   in_accept;
  logic                   dab_start;
  logic [MAG_W-1:0]       mag;
  logic                   dab_busy;
  logic [BCD_W-1:0]       bcd;
  logic [DIG_IDX_W-1:0]   lead;
  cursor_cmd_t            cur_cmd;
  logic [10:0]            cur_addr;
  logic [7:0]             emit_code;
  logic                   emit_last;
  logic                   slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign mag         = in_req_i.number[63] ? MAG_W'(-in_req_i.number)
                                           : MAG_W'(in_req_i.number);

  tccw_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .mag_i   (mag),
    .busy_o  (dab_busy),
    .bcd_o   (bcd)
  );

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cur_cmd),
    .addr_o (cur_addr)
  );

  // highest nonzero digit, zero prints as one digit
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        lead = DIG_IDX_W'(i);
      end
    end
  end

  always_comb begin
    emit_code = DIGIT_ZERO + {4'b0, bcd[4*dig_idx_q +: 4]};
    emit_last = (dig_idx_q == '0);
    if (is_char_q) begin
      emit_code = char_q;
      emit_last = 1'b1;
    end else if (neg_q) begin
      emit_code = MINUS_SIGN;
      emit_last = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    is_char_d   = is_char_q;
    char_d      = char_q;
    neg_d       = neg_q;
    dig_idx_d   = dig_idx_q;
    dab_start   = 1'b0;
    cur_cmd     = '0;
    out_load    = 1'b0;
    out_cell_d  = out_cell_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_req_i.req_type == REQ_CHAR) begin
            if (in_req_i.char_code == NEWLINE_CODE) begin
              cur_cmd.newline = 1'b1;
            end else begin
              is_char_d = 1'b1;
              char_d    = in_req_i.char_code;
              neg_d     = 1'b0;
              state_d   = ST_EMIT;
            end
          end else begin
            is_char_d = 1'b0;
            neg_d     = in_req_i.number[63];
            dab_start = 1'b1;
            state_d   = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (!dab_busy) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        dig_idx_d = lead;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load                = 1'b1;
          cur_cmd.advance         = 1'b1;
          out_cell_d.cell_address = cur_addr;
          out_cell_d.cell_value   = {color_q, emit_code};
          out_cell_d.last_of_run  = emit_last;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else if (neg_q) begin
            neg_d = 1'b0;
          end else begin
            dig_idx_d = dig_idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      color_q     <= COLOR_RESET;
      out_valid_q <= 1'b0;
      is_char_q   <= 1'b0;
      neg_q       <= 1'b0;
      dig_idx_q   <= '0;
    end else begin
      state_q   <= state_d;
      is_char_q <= is_char_d;
      neg_q     <= neg_d;
      dig_idx_q <= dig_idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        color_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    out_cell_q <= out_cell_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_cell_o  = out_cell_q;

  a_busy_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_busy |-> state_q == ST_CONV)
    else $error("conversion unit busy outside conversion");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !is_char_q) |-> dig_idx_q < DIG_IDX_W'(NUM_DIGITS))
    else $error("digit index out of range");

  a_char_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req_i.req_type == REQ_CHAR && in_req_i.char_code != NEWLINE_CODE)
    |=> state_q == ST_EMIT && is_char_q)
    else $error("character beat did not go to emit");

  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_cell_d.last_of_run) |=> state_q == ST_IDLE)
    else $error("last cell loaded without returning to idle");

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int unsigned COLUMNS      = 80;
  localparam int unsigned ROWS         = 25;
  localparam int          SETTLE_CYCLES = 80;
  localparam int          LONG_HOLD     = 400;
  localparam int          PHASE_ITEMS   = 30;
  localparam int          MAX_REPORTS   = 10;

  typedef enum int {RX_FREE, RX_COIN, RX_BUSY, RX_PERIODIC} rx_mode_e;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       req_valid  = 1'b0;
  logic       req_stall;
  req_t       req_beat   = '0;
  logic       cell_valid;
  logic       cell_stall = 1'b0;
  cell_t      cell_beat;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = '0;

  req_t  pending_reqs[$];
  cell_t expected_cells[$];

  logic [7:0] text_color = COLOR_RESET;
  int         cur_col    = 0;
  int         cur_row    = 0;
  int         error_count = 0;

  int       burst_left = 4;
  int       gap_left   = 0;
  int       hold_req   = 0;
  int       hold_ack   = 0;
  int       hold_left  = 0;
  int       mode_left  = 0;
  int       rx_cycle   = 0;
  rx_mode_e rx_mode    = RX_FREE;

  text_console_cell_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_req_i   (req_beat),
    .out_valid_o(cell_valid),
    .out_stall_i(cell_stall),
    .out_cell_o (cell_beat),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) cur_row = 0;
  endfunction

  function automatic void put_cell(input logic [7:0] code, input logic last);
    cell_t c;
    c.cell_address = 11'(cur_row * COLUMNS + cur_col);
    c.cell_value   = {text_color, code};
    c.last_of_run  = last;
    expected_cells.push_back(c);
    cur_col++;
    if (cur_col >= COLUMNS) next_row();
  endfunction

  function automatic void predict_cells(input req_t r);
    logic [63:0] mag;
    logic [7:0]  digs[NUM_DIGITS];
    int          nd;
    if (r.req_type == REQ_CHAR) begin
      if (r.char_code == NEWLINE_CODE) next_row();
      else put_cell(r.char_code, 1'b1);
    end else begin
      mag = r.number[63] ? (64'd0 - r.number) : r.number;
      nd  = 0;
      do begin
        digs[nd] = DIGIT_ZERO + 8'(mag % 64'd10);
        nd++;
        mag = mag / 64'd10;
      end while (mag != 0 && nd < NUM_DIGITS - 1);
      if (r.number[63]) put_cell(MINUS_SIGN, 1'b0);
      for (int i = nd - 1; i >= 0; i--) put_cell(digs[i], i == 0);
    end
  endfunction

  function automatic void flag_error(input string what);
    if (error_count < MAX_REPORTS) $display("mismatch: %s", what);
    error_count++;
  endfunction

  function automatic req_t char_req(input logic [7:0] code);
    req_t r;
    r.req_type  = REQ_CHAR;
    r.char_code = code;
    r.number    = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t num_req(input logic signed [63:0] n);
    req_t r;
    r.req_type  = REQ_NUMBER;
    r.char_code = 8'($urandom);
    r.number    = n;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.req_type  = $urandom_range(0, 1) ? REQ_NUMBER : REQ_CHAR;
    r.char_code = ($urandom_range(0, 4) == 0) ? NEWLINE_CODE : 8'($urandom);
    case ($urandom_range(0, 4))
      0: r.number = {$urandom, $urandom};
      1: r.number = 64'($urandom_range(0, 999));
      2: r.number = -$signed({32'd0, $urandom});
      3: r.number = $signed({$urandom, $urandom}) >>> $urandom_range(1, 62);
      default: r.number = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                               : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    return r;
  endfunction

  // request driver: bursts with random gaps
  always @(posedge clk) begin : req_driver
    bit free;
    if (rst_n) begin
      free = !req_valid || !req_stall;
      if (free) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_beat  <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // cell receiver stall pattern, with an occasional long hold
  always @(posedge clk) begin : cell_receiver
    if (hold_left > 0) begin
      hold_left--;
      cell_stall <= 1'b1;
    end else if (hold_req != hold_ack) begin
      hold_ack   = hold_req;
      hold_left  = LONG_HOLD;
      cell_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:  cell_stall <= 1'b0;
        RX_COIN:  cell_stall <= 1'($urandom_range(0, 1));
        RX_BUSY:  cell_stall <= ($urandom_range(0, 3) != 0);
        default:  cell_stall <= (rx_cycle % 3 == 0);
      endcase
    end
    rx_cycle++;
  end

  // check cell beats, then predict from accepted request beats
  always @(posedge clk) begin : beat_monitor
    cell_t want;
    if (rst_n) begin
      if (cell_valid && !cell_stall) begin
        if (expected_cells.size() == 0) begin
          flag_error($sformatf("unexpected cell addr %0d value %h last %b",
                               cell_beat.cell_address, cell_beat.cell_value,
                               cell_beat.last_of_run));
        end else begin
          want = expected_cells.pop_front();
          if (cell_beat.cell_address !== want.cell_address ||
              cell_beat.cell_value   !== want.cell_value ||
              cell_beat.last_of_run  !== want.last_of_run) begin
            flag_error($sformatf("addr exp %0d got %0d, value exp %h got %h, last exp %b got %b",
                                 want.cell_address, cell_beat.cell_address,
                                 want.cell_value, cell_beat.cell_value,
                                 want.last_of_run, cell_beat.last_of_run));
          end
        end
      end
      if (req_valid && !req_stall) predict_cells(req_beat);
    end
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    text_color = c;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_reqs.push_back(random_req());
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset color
    pending_reqs.push_back(char_req(8'h41));
    pending_reqs.push_back(char_req(8'h00));
    pending_reqs.push_back(char_req(8'hFF));
    pending_reqs.push_back(char_req(NEWLINE_CODE));
    pending_reqs.push_back(num_req(64'sd0));
    pending_reqs.push_back(num_req(64'sd1));
    pending_reqs.push_back(num_req(-64'sd1));
    pending_reqs.push_back(num_req(64'h7FFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(num_req(64'h8000_0000_0000_0000));
    pending_reqs.push_back(num_req(-64'sd10));
    pending_reqs.push_back(num_req(64'sd1000000000000000000));
    pending_reqs.push_back(num_req(64'sd9));
    pending_reqs.push_back(num_req(64'sd10));
    pending_reqs.push_back(char_req(NEWLINE_CODE));
    pending_reqs.push_back(char_req(MINUS_SIGN));
    pending_reqs.push_back(char_req(DIGIT_ZERO));
    pending_reqs.push_back(char_req(8'h7F));
    pending_reqs.push_back(char_req(8'h80));
    pending_reqs.push_back(char_req(NEWLINE_CODE));
    pending_reqs.push_back(num_req(64'sd42));
    drain();

    write_color(8'hFF);
    queue_random(PHASE_ITEMS);
    drain();

    // long receiver hold while the sender keeps offering beats
    write_color(8'h00);
    hold_req <= hold_req + 1;
    queue_random(PHASE_ITEMS);
    drain();

    repeat (3) begin
      write_color(8'($urandom));
      queue_random(PHASE_ITEMS);
      drain();
    end

    if (error_count == 0 && expected_cells.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[text_console_cell_writer_top.f]
src/tccw_pkg.sv
src/tccw_dabble.sv
src/tccw_cursor.sv
src/text_console_cell_writer_top.sv
tb/tb_top.sv
